[design/wivf_pkg.sv]
// shared types and constants for the windowed input vote filter
`timescale 1ns / 1ps
`default_nettype none

package wivf_pkg;

  localparam int DATA_W = 16;
  localparam int THR_W  = 6;

  localparam logic [THR_W-1:0]  THRESHOLD_RST  = 6'd36;
  localparam logic [DATA_W-1:0] POL_KEEP       = 16'hffc0;
  localparam logic [DATA_W-1:0] MASK_FORCE_ONE = 16'h003f;
  localparam logic [DATA_W-1:0] MASK_KEEP      = 16'h3fff;

  typedef enum logic [1:0] {
    CFG_VOTE_THRESHOLD = 2'd0,
    CFG_POLARITY_BITS  = 2'd1,
    CFG_CHANNEL_MASK   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic             shift;
    logic [THR_W-1:0] threshold;
  } tally_ctl_t;

endpackage

`default_nettype wire

[design/windowed_input_vote_filter_top.sv]
// top level of the windowed input vote filter
//
// usage: each transfer on the in_ channel carries one 16-bit raw sample of
// the input pins. the sample enters a chain of WINDOW_DEPTH cells that shifts
// by one at every transfer, and the sample leaving the far end is taken out
// of the per-channel ones counts while the new one is added.
// a channel votes active when its count is below vote_threshold.
// each transfer yields one result on the out_ channel: filtered_bitmap and
// status_bitmap (polarity applied, then masked).
// results are registered, in the skid entry while the output one is held.
// throughput: one sample per cycle while in_stall is low (single-step counts).
// the output register has a skid entry behind it, so in_stall is a flop:
// it rises only when both entries hold a result and out_stall is high.
// reset clears the window chain, the counts, the result entries and loads
// the register defaults (threshold 36, polarity 0, mask 0).
// the cfg_ channel is always ready; write it only while no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module windowed_input_vote_filter_top #(
  parameter int WINDOW_DEPTH = 48,
  parameter int CHANNELS     = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_raw_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [15:0] out_filtered_bitmap,
  output logic      [15:0] out_status_bitmap,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [16:0] CHAN_ONES = (17'd1 << CHANNELS) - 17'd1;
  localparam logic [15:0] CHAN_MASK = CHAN_ONES[15:0];

  // configuration registers
  logic [wivf_pkg::THR_W-1:0]  threshold_r;
  logic [wivf_pkg::DATA_W-1:0] polarity_r;
  logic [wivf_pkg::DATA_W-1:0] mask_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= wivf_pkg::THRESHOLD_RST;
      polarity_r  <= '0;
      mask_r      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (wivf_pkg::cfg_idx_t'(cfg_index))
        wivf_pkg::CFG_VOTE_THRESHOLD: threshold_r <= cfg_data[wivf_pkg::THR_W-1:0];
        wivf_pkg::CFG_POLARITY_BITS:  polarity_r  <= cfg_data;
        wivf_pkg::CFG_CHANNEL_MASK:   mask_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  logic out_valid_r;
  logic skid_valid_r;
  logic in_acc;
  logic out_take;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  wivf_pkg::tally_ctl_t tally_ctl;
  assign tally_ctl.shift     = in_acc;
  assign tally_ctl.threshold = threshold_r;

  // window chain
  logic [CHANNELS-1:0] fresh;
  logic [CHANNELS-1:0] tap [WINDOW_DEPTH];

  assign fresh = in_raw_sample[CHANNELS-1:0];

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      wivf_cell #(.W(CHANNELS)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (in_acc),
        .d     (fresh),
        .q     (tap[k])
      );
    end else begin : g_body
      wivf_cell #(.W(CHANNELS)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (in_acc),
        .d     (tap[k-1]),
        .q     (tap[k])
      );
    end
  end

  // per-channel counts
  logic [CHANNELS-1:0] active;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_tally
    wivf_tally #(.CNT_W(CNT_W)) u_tally (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (tally_ctl),
      .new_bit (fresh[c]),
      .old_bit (tap[WINDOW_DEPTH-1][c]),
      .active  (active[c])
    );
  end

  // result formatting
  logic [15:0] filt_full;
  logic [15:0] pol_eff;
  logic [15:0] mask_eff;
  logic [15:0] status_full;

  assign filt_full   = 16'(active);
  assign pol_eff     = polarity_r & wivf_pkg::POL_KEEP;
  assign mask_eff    = (mask_r | wivf_pkg::MASK_FORCE_ONE) & wivf_pkg::MASK_KEEP;
  assign status_full = ~(filt_full ^ pol_eff) & mask_eff & CHAN_MASK;

  // output register and skid entry
  logic [15:0] out_filt_r;
  logic [15:0] out_stat_r;
  logic [15:0] skid_filt_r;
  logic [15:0] skid_stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_filt_r <= skid_filt_r;
        out_stat_r <= skid_stat_r;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_filt_r <= filt_full;
        out_stat_r <= status_full;
      end else begin
        skid_filt_r <= filt_full;
        skid_stat_r <= status_full;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_bitmap = out_filt_r;
  assign out_status_bitmap   = out_stat_r;

  // checks
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the output register is empty");

  a_accept_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("input transfer without a result in the next cycle");

  a_status_top_clear : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_stat_r[15:14] == 2'b00))
    else $error("status bits 15:14 set");

endmodule

`default_nettype wire

[design/wivf_cell.sv]
// one window cell: holds one sample and passes it on at every transfer
`timescale 1ns / 1ps
`default_nettype none

module wivf_cell #(
  parameter int W = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         shift,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

[design/wivf_tally.sv]
// per-channel running count of ones in the window and threshold vote
`timescale 1ns / 1ps
`default_nettype none

module wivf_tally #(
  parameter int CNT_W = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire wivf_pkg::tally_ctl_t ctl,
  input  wire logic                 new_bit,
  input  wire logic                 old_bit,
  output logic                      active
);

  localparam int CMP_W = (CNT_W > wivf_pkg::THR_W) ? CNT_W : wivf_pkg::THR_W;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  always_comb begin
    case ({new_bit, old_bit})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.shift) begin
      count_r <= count_nxt;
    end
  end

  assign active = (CMP_W'(count_nxt) < CMP_W'(ctl.threshold));

endmodule

`default_nettype wire

[sim/windowed_input_vote_filter_top_tb.sv]
// testbench for the windowed input vote filter: directed table, then random debounce traffic
`timescale 1ns / 1ps

module windowed_input_vote_filter_top_tb;

  localparam int WIN_DEPTH    = 48;
  localparam int NUM_CHAN     = 16;
  localparam int HOLD_CYCLES  = 60;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SECT_ITEMS   = 115;
  localparam int NUM_SECTIONS = 6;
  localparam int NUM_ROWS     = 23;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [15:0] data;
    logic        typed;
    logic [15:0] exp_filt;
    logic [15:0] exp_stat;
  } dir_row_t;

  typedef struct packed {
    logic [15:0] filtered;
    logic [15:0] status;
  } vote_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_raw_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_filtered_bitmap;
  logic [15:0] out_status_bitmap;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // typed expectation riding along with the sample
  logic        in_typed = 1'b0;
  logic [15:0] in_exp_filt = '0;
  logic [15:0] in_exp_stat = '0;

  // predictor state
  logic [15:0] sample_window [WIN_DEPTH];
  logic [5:0]  window_slot;
  logic [5:0]  ones_tally [NUM_CHAN];
  logic [5:0]  vote_thr;
  logic [15:0] pol_reg;
  logic [15:0] mask_reg;

  vote_result_t pending_results [$];
  vote_result_t want_r;
  vote_result_t got_r;

  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  dir_row_t dir_rows [NUM_ROWS] = '{
    '{ROW_SAMPLE, '0,                           16'h0000, 1'b1, 16'hffff, 16'h0000},
    '{ROW_SAMPLE, '0,                           16'hffff, 1'b1, 16'hffff, 16'h0000},
    '{ROW_SAMPLE, '0,                           16'ha5a5, 1'b0, '0,       '0},
    '{ROW_SAMPLE, '0,                           16'h5a5a, 1'b0, '0,       '0},
    '{ROW_WRITE,  wivf_pkg::CFG_VOTE_THRESHOLD, 16'd0,    1'b0, '0,       '0},
    '{ROW_WRITE,  wivf_pkg::CFG_CHANNEL_MASK,   16'hffff, 1'b0, '0,       '0},
    '{ROW_SAMPLE, '0,                           16'h0001, 1'b1, 16'h0000, 16'h3fff},
    '{ROW_WRITE,  wivf_pkg::CFG_POLARITY_BITS,  16'hffff, 1'b0, '0,       '0},
    '{ROW_WRITE,  wivf_pkg::CFG_VOTE_THRESHOLD, 16'd63,   1'b0, '0,       '0},
    '{ROW_SAMPLE, '0,                           16'h1234, 1'b1, 16'hffff, 16'h3fc0},
    '{ROW_WRITE,  CFG_UNUSED,                   16'hffff, 1'b0, '0,       '0},
    '{ROW_SAMPLE, '0,                           16'h8000, 1'b1, 16'hffff, 16'h3fc0},
    '{ROW_WRITE,  wivf_pkg::CFG_VOTE_THRESHOLD, 16'd48,   1'b0, '0,       '0},
    '{ROW_SAMPLE, '0,                           16'hffff, 1'b0, '0,       '0},
    '{ROW_WRITE,  wivf_pkg::CFG_VOTE_THRESHOLD, 16'd1,    1'b0, '0,       '0},
    '{ROW_SAMPLE, '0,                           16'h0000, 1'b0, '0,       '0},
    '{ROW_SAMPLE, '0,                           16'hffff, 1'b0, '0,       '0},
    '{ROW_WRITE,  wivf_pkg::CFG_POLARITY_BITS,  16'h0000, 1'b0, '0,       '0},
    '{ROW_WRITE,  wivf_pkg::CFG_CHANNEL_MASK,   16'h0000, 1'b0, '0,       '0},
    '{ROW_SAMPLE, '0,                           16'h7fff, 1'b0, '0,       '0},
    '{ROW_WRITE,  wivf_pkg::CFG_VOTE_THRESHOLD, 16'd36,   1'b0, '0,       '0},
    '{ROW_SAMPLE, '0,                           16'hfffe, 1'b0, '0,       '0},
    '{ROW_SAMPLE, '0,                           16'hc03f, 1'b0, '0,       '0}
  };

  logic [5:0] sect_thr [NUM_SECTIONS] = '{6'd36, 6'd48, 6'd0, 6'd63, 6'd47, 6'd1};

  windowed_input_vote_filter_top #(
    .WINDOW_DEPTH(WIN_DEPTH),
    .CHANNELS(NUM_CHAN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_raw_sample(in_raw_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_filtered_bitmap(out_filtered_bitmap),
    .out_status_bitmap(out_status_bitmap),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_vote_state();
    for (int i = 0; i < WIN_DEPTH; i++) sample_window[i] = '0;
    for (int ch = 0; ch < NUM_CHAN; ch++) ones_tally[ch] = '0;
    window_slot = '0;
    vote_thr = wivf_pkg::THRESHOLD_RST;
    pol_reg = '0;
    mask_reg = '0;
  endfunction

  function automatic void apply_reg_write(input logic [1:0] idx, input logic [15:0] data);
    case (idx)
      wivf_pkg::CFG_VOTE_THRESHOLD: vote_thr = data[5:0];
      wivf_pkg::CFG_POLARITY_BITS:  pol_reg = data;
      wivf_pkg::CFG_CHANNEL_MASK:   mask_reg = data;
      default: ;
    endcase
  endfunction

  function automatic vote_result_t vote_step(input logic [15:0] fresh);
    logic [15:0] evicted;
    vote_result_t r;
    evicted = sample_window[window_slot];
    r.filtered = '0;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      ones_tally[ch] = ones_tally[ch] + 6'(fresh[ch]) - 6'(evicted[ch]);
      if (ones_tally[ch] < vote_thr) r.filtered[ch] = 1'b1;
    end
    sample_window[window_slot] = fresh;
    window_slot = (window_slot == WIN_DEPTH - 1) ? '0 : window_slot + 6'd1;
    r.status = ~(r.filtered ^ (pol_reg & wivf_pkg::POL_KEEP)) &
               ((mask_reg | wivf_pkg::MASK_FORCE_ONE) & wivf_pkg::MASK_KEEP);
    return r;
  endfunction

  // checks each result transfer, then predicts each sample transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected result: filtered %h status %h", $time,
                   out_filtered_bitmap, out_status_bitmap);
        end else begin
          want_r = pending_results.pop_front();
          if (out_filtered_bitmap !== want_r.filtered) begin
            mismatch_count++;
            $display("%0t filtered_bitmap expected %h actual %h", $time,
                     want_r.filtered, out_filtered_bitmap);
          end
          if (out_status_bitmap !== want_r.status) begin
            mismatch_count++;
            $display("%0t status_bitmap expected %h actual %h", $time,
                     want_r.status, out_status_bitmap);
          end
        end
      end
      if (in_valid && !in_stall) begin
        got_r = vote_step(in_raw_sample);
        if (in_typed) got_r = '{in_exp_filt, in_exp_stat};
        pending_results.push_back(got_r);
      end
    end
  end

  // receiver: random stall, plus long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[windowed_input_vote_filter_top] ERROR");
      $finish;
    end
  end

  task automatic send_sample(input logic [15:0] s, input logic typed,
                             input logic [15:0] ef, input logic [15:0] es);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_sample <= s;
    in_typed <= typed;
    in_exp_filt <= ef;
    in_exp_stat <= es;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly steady levels with contact bounce, some pure noise
  task automatic random_section(input int n_items, input bit pause_mid);
    int sent;
    int run_len;
    logic [15:0] base;
    logic [15:0] s;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        case ($urandom_range(3))
          0: base = 16'h0000;
          1: base = 16'hffff;
          default: base = 16'($urandom);
        endcase
        run_len = $urandom_range(1, 60);
      end else begin
        base = 16'($urandom);
        run_len = 1;
      end
      if (run_len > n_items - sent) run_len = n_items - sent;
      repeat (run_len) begin
        s = base;
        if ($urandom_range(99) < 30) s[$urandom_range(15)] = ~s[$urandom_range(15)];
        if ($urandom_range(99) < 10) s = s ^ 16'($urandom);
        send_sample(s, 1'b0, '0, '0);
        sent++;
        if (pause_mid && sent == n_items / 2) drain_results();
      end
    end
  endtask

  initial begin
    clear_vote_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct <= 20;
    recv_idle_pct <= 72;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_WRITE)
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      else
        send_sample(dir_rows[r].data, dir_rows[r].typed, dir_rows[r].exp_filt,
                    dir_rows[r].exp_stat);
    end

    for (int sct = 0; sct < NUM_SECTIONS; sct++) begin
      write_reg(wivf_pkg::CFG_VOTE_THRESHOLD,
                (sct == NUM_SECTIONS - 1) ? 16'($urandom_range(63)) : 16'(sect_thr[sct]));
      write_reg(wivf_pkg::CFG_POLARITY_BITS, (sct == 1) ? 16'hffff : 16'($urandom));
      write_reg(wivf_pkg::CFG_CHANNEL_MASK, (sct == 2) ? 16'h0000 : 16'($urandom));
      if (sct == 2) begin
        send_idle_pct <= 72;
        recv_idle_pct <= 20;
      end else if (sct == 4) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        hold_requests <= hold_requests + 1;
      end
      random_section(SECT_ITEMS, sct == 3);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[windowed_input_vote_filter_top] OK");
    end else begin
      $display("[windowed_input_vote_filter_top] ERROR");
    end
    $finish;
  end

endmodule
